// File: rtl/core/swsh_pkg.sv
// shared constants, register codes and rounding helper for the spectral wiener shrink
`default_nettype none
package swsh_pkg;

    localparam int COEF_WIDTH_DEF = 32;

    localparam int S_DATA_W   = 248;
    localparam int M_DATA_W   = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 63;

    // stage count from input word to output register
    localparam int PIPE_DEPTH = 64;

    localparam logic [20:0] ONE_Q16 = 21'd65536;

    typedef enum logic [2:0] {
        REG_MODE        = 3'd0,
        REG_NOISE_POWER = 3'd1,
        REG_LOW_LIMIT   = 3'd2,
        REG_SHARPEN     = 3'd3,
        REG_SHARPEN_MIN = 3'd4,
        REG_SHARPEN_MAX = 3'd5,
        REG_DEHALO      = 3'd6,
        REG_HALO_POWER  = 3'd7
    } cfg_reg_t;

    // arithmetic shift right with rounding half away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned n);
        logic [63:0] mag;
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (n - 1))) >> n;
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/spectral_wiener_shrink.sv
// Spectral Wiener shrink: one complex bin in and one filtered bin out per clock cycle while the
// output word is taken; most of the pipeline depth lies in the pipelined dividers: the three 32-bit
// power ratios take one stage per quotient bit, followed by the 16-stage square root and the
// 17-stage dehalo reciprocal. All stages advance together; when the output word is not taken
// the whole pipeline holds, so nothing is lost or repeated. The user must write registers
// through the plain write port only while no bin is in flight; the block does not enforce it.
`default_nettype none
module spectral_wiener_shrink #(
    parameter int COEF_WIDTH = swsh_pkg::COEF_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [swsh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [swsh_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // re_in, im_in, grid_re, grid_im, grid_fraction, pattern_power, sharpen_weight,
    // dehalo_weight, zero fill
    input  wire logic [swsh_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // re_out, im_out
    output logic      [swsh_pkg::M_DATA_W-1:0]   m_tdata
);

    import swsh_pkg::*;

    localparam logic signed [63:0] COEF_MAX = (64'sd1 <<< (COEF_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] COEF_MIN = -COEF_MAX - 64'sd1;
    localparam logic [64:0] POW_MAX = {2'b00, {63{1'b1}}};

    function automatic logic signed [31:0] sat_coef(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v > COEF_MAX) ? COEF_MAX : ((v < COEF_MIN) ? COEF_MIN : v);
        return r[31:0];
    endfunction

    // configuration
    logic [1:0]         mode_reg;
    logic [62:0]        noise_reg;
    logic [15:0]        low_reg;
    logic signed [15:0] sharp_reg;
    logic [62:0]        smin_reg;
    logic [62:0]        smax_reg;
    logic [15:0]        dehalo_reg;
    logic [62:0]        halo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= '0;
            noise_reg  <= '0;
            low_reg    <= '0;
            sharp_reg  <= '0;
            smin_reg   <= '0;
            smax_reg   <= '0;
            dehalo_reg <= '0;
            halo_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_MODE:        mode_reg   <= cfg_data[1:0];
                REG_NOISE_POWER: noise_reg  <= cfg_data[62:0];
                REG_LOW_LIMIT:   low_reg    <= cfg_data[15:0];
                REG_SHARPEN:     sharp_reg  <= $signed(cfg_data[15:0]);
                REG_SHARPEN_MIN: smin_reg   <= cfg_data[62:0];
                REG_SHARPEN_MAX: smax_reg   <= cfg_data[62:0];
                REG_DEHALO:      dehalo_reg <= cfg_data[15:0];
                REG_HALO_POWER:  halo_reg   <= cfg_data[62:0];
                default:         mode_reg   <= mode_reg;
            endcase
        end
    end

    // input word fields
    logic signed [31:0] in_re, in_im, in_gre, in_gim;
    logic signed [17:0] in_gf;
    logic [62:0]        in_pat;
    logic [15:0]        in_ws, in_wd;

    assign in_re  = $signed(s_tdata[31:0]);
    assign in_im  = $signed(s_tdata[63:32]);
    assign in_gre = $signed(s_tdata[95:64]);
    assign in_gim = $signed(s_tdata[127:96]);
    assign in_gf  = $signed(s_tdata[145:128]);
    assign in_pat = s_tdata[208:146];
    assign in_ws  = s_tdata[224:209];
    assign in_wd  = s_tdata[240:225];

    logic                  pipe_en;
    logic [PIPE_DEPTH-1:0] vld_reg;

    assign pipe_en  = !vld_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = pipe_en;
    assign m_tvalid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // side payload delay lines (numbers are stage counts)
    logic [63:0] bin2;
    logic [62:0] pat5;
    logic        g_zero22;
    logic [15:0] wd37, ws55;
    logic [15:0] g58, g61;
    logic [16:0] d60;
    logic [63:0] c62, gc63;

    // stage registers
    logic signed [49:0] prod_r_reg, prod_i_reg, prod_r_next, prod_i_next;
    logic signed [31:0] gc_r_reg, gc_i_reg, gc_r_next, gc_i_next;
    logic signed [31:0] cr_reg, ci_reg, cr_next, ci_next;
    logic [63:0]        sq_r_reg, sq_i_reg, sq_r_next, sq_i_next;
    logic [62:0]        p_reg, p_next;
    logic [62:0]        g_num_reg, g_den_reg, g_num_next, g_den_next;
    logic               g_zero_reg, g_zero_next;
    logic [63:0]        a_num_reg, a_den_reg, a_num_next, a_den_next;
    logic [63:0]        b_num_reg, b_den_reg, b_num_next, b_den_next;
    logic [63:0]        q_num_reg, q_den_reg, q_num_next, q_den_next;
    logic [15:0]        g_reg, g_next;
    logic [31:0]        k_reg, k_next;
    logic [31:0]        ab_hi_reg, ab_hi_next;
    logic [19:0]        kq_hi_reg, kq_hi_next;
    logic [20:0]        dden_reg, dden_next;
    logic [31:0]        wr_reg, wr_next;
    logic signed [48:0] sm_reg, sm_next;
    logic signed [21:0] s_reg, s_next;
    logic signed [38:0] gs_reg, gs_next;
    logic signed [22:0] f1_reg, f1_next;
    logic signed [40:0] fd_reg, fd_next;
    logic signed [23:0] f_reg, f_next;
    logic signed [55:0] pr_r_reg, pr_i_reg, pr_r_next, pr_i_next;
    logic signed [31:0] out_r_reg, out_i_reg, out_r_next, out_i_next;

    logic [15:0] g_quo;
    logic [31:0] a_quo, b_quo, q_quo;
    logic [16:0] d_quo;
    logic [15:0] root;

    swsh_delay #(.W(64), .N(2)) u_dly_bin (
        .aclk(aclk), .en(pipe_en), .d({in_im, in_re}), .q(bin2));
    swsh_delay #(.W(63), .N(5)) u_dly_pat (
        .aclk(aclk), .en(pipe_en), .d(in_pat), .q(pat5));
    swsh_delay #(.W(16), .N(37)) u_dly_wd (
        .aclk(aclk), .en(pipe_en), .d(in_wd), .q(wd37));
    swsh_delay #(.W(16), .N(55)) u_dly_ws (
        .aclk(aclk), .en(pipe_en), .d(in_ws), .q(ws55));
    swsh_delay #(.W(1), .N(16)) u_dly_gz (
        .aclk(aclk), .en(pipe_en), .d(g_zero_reg), .q(g_zero22));
    swsh_delay #(.W(16), .N(35)) u_dly_g58 (
        .aclk(aclk), .en(pipe_en), .d(g_reg), .q(g58));
    swsh_delay #(.W(16), .N(3)) u_dly_g61 (
        .aclk(aclk), .en(pipe_en), .d(g58), .q(g61));
    swsh_delay #(.W(17), .N(3)) u_dly_d (
        .aclk(aclk), .en(pipe_en), .d(d_quo), .q(d60));
    swsh_delay #(.W(64), .N(59)) u_dly_c (
        .aclk(aclk), .en(pipe_en), .d({ci_reg, cr_reg}), .q(c62));
    swsh_delay #(.W(64), .N(61)) u_dly_gc (
        .aclk(aclk), .en(pipe_en), .d({gc_i_reg, gc_r_reg}), .q(gc63));

    // wiener gain and the three power ratios
    swsh_fdiv #(.W(63), .QB(16)) u_div_g (
        .aclk(aclk), .en(pipe_en), .num(g_num_reg), .den(g_den_reg), .quo(g_quo));
    swsh_fdiv #(.W(64), .QB(32)) u_div_a (
        .aclk(aclk), .en(pipe_en), .num(a_num_reg), .den(a_den_reg), .quo(a_quo));
    swsh_fdiv #(.W(64), .QB(32)) u_div_b (
        .aclk(aclk), .en(pipe_en), .num(b_num_reg), .den(b_den_reg), .quo(b_quo));
    swsh_fdiv #(.W(64), .QB(32)) u_div_q (
        .aclk(aclk), .en(pipe_en), .num(q_num_reg), .den(q_den_reg), .quo(q_quo));
    // dehalo cut: 2^32 / den written as 2^15 * 2^17 / den
    swsh_fdiv #(.W(21), .QB(17)) u_div_d (
        .aclk(aclk), .en(pipe_en), .num(21'd32768), .den(dden_reg), .quo(d_quo));
    // upper root bits only need the upper half of a*b
    swsh_isqrt #(.IW(32)) u_sqrt (
        .aclk(aclk), .en(pipe_en), .x(ab_hi_reg), .root(root));

    always_comb begin
        logic [64:0] psum;
        logic [62:0] noise;
        logic [63:0] ab_full;
        logic [63:0] kq_full;
        logic [15:0] gq;

        // grid correction
        prod_r_next = 50'(in_gf) * 50'(in_gre);
        prod_i_next = 50'(in_gf) * 50'(in_gim);
        gc_r_next = mode_reg[1] ? sat_coef(rnd_shift(64'(prod_r_reg), 16)) : '0;
        gc_i_next = mode_reg[1] ? sat_coef(rnd_shift(64'(prod_i_reg), 16)) : '0;
        cr_next = sat_coef(64'($signed(bin2[31:0])) - 64'(gc_r_reg));
        ci_next = sat_coef(64'($signed(bin2[63:32])) - 64'(gc_i_reg));

        // power, the extra lsb keeps it nonzero
        sq_r_next = 64'(64'(cr_reg) * 64'(cr_reg));
        sq_i_next = 64'(64'(ci_reg) * 64'(ci_reg));
        psum = {1'b0, sq_r_reg} + {1'b0, sq_i_reg} + 65'd1;
        p_next = (psum > POW_MAX) ? POW_MAX[62:0] : psum[62:0];

        noise = mode_reg[0] ? pat5 : noise_reg;
        g_zero_next = (noise >= p_reg);
        g_num_next  = g_zero_next ? '0 : 63'(p_reg - noise);
        g_den_next  = p_reg;
        a_num_next  = {1'b0, p_reg};
        a_den_next  = {1'b0, p_reg} + {1'b0, smin_reg};
        b_num_next  = {1'b0, smax_reg};
        b_den_next  = {1'b0, p_reg} + {1'b0, smax_reg};
        q_num_next  = {1'b0, p_reg};
        q_den_next  = {1'b0, p_reg} + {1'b0, halo_reg};

        gq = g_zero22 ? '0 : g_quo;
        g_next = (gq < low_reg) ? low_reg : gq;

        // zero power offsets make the ratio exactly one
        k_next = 32'(dehalo_reg) * 32'(wd37);
        ab_full = 64'(a_quo) * 64'(b_quo);
        ab_hi_next = (smin_reg == '0) ? b_quo : ab_full[63:32];
        kq_full = 64'(k_reg) * 64'(q_quo);
        kq_hi_next = (halo_reg == '0) ? k_reg[31:12] : kq_full[63:44];
        dden_next = 21'(kq_hi_reg) + ONE_Q16;

        // sharpen boost
        wr_next = 32'(ws55) * 32'(root);
        sm_next = 49'(sharp_reg) * 49'($signed({1'b0, wr_reg}));
        s_next = 22'(64'(ONE_Q16) + rnd_shift(64'(sm_reg), 28));

        gs_next = 39'($signed({1'b0, g58})) * 39'(s_reg);
        f1_next = 23'(rnd_shift(64'(gs_reg), 16));
        fd_next = 41'(f1_reg) * 41'($signed({1'b0, d60}));
        f_next = mode_reg[0] ? $signed({8'b0, g61}) : 24'(rnd_shift(64'(fd_reg), 16));

        pr_r_next = 56'($signed(c62[31:0])) * 56'(f_reg);
        pr_i_next = 56'($signed(c62[63:32])) * 56'(f_reg);
        out_r_next = sat_coef(rnd_shift(64'(pr_r_reg), 16) + 64'($signed(gc63[31:0])));
        out_i_next = sat_coef(rnd_shift(64'(pr_i_reg), 16) + 64'($signed(gc63[63:32])));
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            prod_r_reg <= prod_r_next;
            prod_i_reg <= prod_i_next;
            gc_r_reg   <= gc_r_next;
            gc_i_reg   <= gc_i_next;
            cr_reg     <= cr_next;
            ci_reg     <= ci_next;
            sq_r_reg   <= sq_r_next;
            sq_i_reg   <= sq_i_next;
            p_reg      <= p_next;
            g_num_reg  <= g_num_next;
            g_den_reg  <= g_den_next;
            g_zero_reg <= g_zero_next;
            a_num_reg  <= a_num_next;
            a_den_reg  <= a_den_next;
            b_num_reg  <= b_num_next;
            b_den_reg  <= b_den_next;
            q_num_reg  <= q_num_next;
            q_den_reg  <= q_den_next;
            g_reg      <= g_next;
            k_reg      <= k_next;
            ab_hi_reg  <= ab_hi_next;
            kq_hi_reg  <= kq_hi_next;
            dden_reg   <= dden_next;
            wr_reg     <= wr_next;
            sm_reg     <= sm_next;
            s_reg      <= s_next;
            gs_reg     <= gs_next;
            f1_reg     <= f1_next;
            fd_reg     <= fd_next;
            f_reg      <= f_next;
            pr_r_reg   <= pr_r_next;
            pr_i_reg   <= pr_i_next;
            out_r_reg  <= out_r_next;
            out_i_reg  <= out_i_next;
        end
    end

    assign m_tdata = {out_i_reg, out_r_reg};

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word did not enter the pipeline");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_last_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_en && vld_reg[PIPE_DEPTH-2] |=> m_tvalid)
        else $error("word lost before output register");

    a_gain_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[22] |-> g_reg >= low_reg)
        else $error("wiener gain below floor");
`endif

endmodule
`default_nettype wire

// File: rtl/core/swsh_delay.sv
// enabled delay line for payload that rides alongside the pipeline
`default_nettype none
module swsh_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);

    logic [W-1:0] tap_reg [N];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= d;
            for (int i = 1; i < N; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[N-1];

endmodule
`default_nettype wire

// File: rtl/core/swsh_fdiv.sv
// pipelined restoring divider, floor(num * 2^QB / den), one quotient bit per stage
`default_nettype none
module swsh_fdiv #(
    parameter int W  = 64,
    parameter int QB = 32
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [W-1:0]  num,
    input  wire logic [W-1:0]  den,
    output logic      [QB-1:0] quo
);

    logic [W-1:0]  rem_reg  [QB];
    logic [W-1:0]  rem_next [QB];
    logic [W-1:0]  den_reg  [QB];
    logic [W-1:0]  den_next [QB];
    logic [QB-1:0] quo_reg  [QB];
    logic [QB-1:0] quo_next [QB];

    always_comb begin
        logic [W:0]    t;
        logic [W-1:0]  r_in;
        logic [W-1:0]  d_in;
        logic [QB-1:0] q_in;
        for (int i = 0; i < QB; i++) begin
            if (i == 0) begin
                r_in = num;
                d_in = den;
                q_in = '0;
            end else begin
                r_in = rem_reg[i-1];
                d_in = den_reg[i-1];
                q_in = quo_reg[i-1];
            end
            t = {r_in, 1'b0};
            den_next[i] = d_in;
            if (t >= {1'b0, d_in}) begin
                rem_next[i] = W'(t - {1'b0, d_in});
                quo_next[i] = {q_in[QB-2:0], 1'b1};
            end else begin
                rem_next[i] = t[W-1:0];
                quo_next[i] = {q_in[QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < QB; i++) begin
                rem_reg[i] <= rem_next[i];
                den_reg[i] <= den_next[i];
                quo_reg[i] <= quo_next[i];
            end
        end
    end

    assign quo = quo_reg[QB-1];

endmodule
`default_nettype wire

// File: rtl/core/swsh_isqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none
module swsh_isqrt #(
    parameter int IW = 32
) (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [IW-1:0]   x,
    output logic      [IW/2-1:0] root
);

    localparam int RW = IW / 2;

    logic [RW+1:0] rem_reg   [RW];
    logic [RW+1:0] rem_next  [RW];
    logic [RW-1:0] root_reg  [RW];
    logic [RW-1:0] root_next [RW];
    logic [IW-1:0] x_reg     [RW];
    logic [IW-1:0] x_next    [RW];

    always_comb begin
        logic [RW+3:0] rem_t;
        logic [RW+3:0] trial;
        logic [RW+1:0] r_in;
        logic [RW-1:0] s_in;
        logic [IW-1:0] x_in;
        for (int i = 0; i < RW; i++) begin
            if (i == 0) begin
                r_in = '0;
                s_in = '0;
                x_in = x;
            end else begin
                r_in = rem_reg[i-1];
                s_in = root_reg[i-1];
                x_in = x_reg[i-1];
            end
            rem_t = {r_in, x_in[IW-1:IW-2]};
            trial = {2'b00, s_in, 2'b01};
            x_next[i] = {x_in[IW-3:0], 2'b00};
            if (rem_t >= trial) begin
                rem_next[i]  = (RW+2)'(rem_t - trial);
                root_next[i] = {s_in[RW-2:0], 1'b1};
            end else begin
                rem_next[i]  = rem_t[RW+1:0];
                root_next[i] = {s_in[RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < RW; i++) begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                x_reg[i]    <= x_next[i];
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule
`default_nettype wire
